### hdl/scfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_pkg
// Types and constants shared by the serial command frame parser modules.
// ----------------------------------------------------------------------------
package scfp_pkg;

  // Longest accepted length field (id + command + data bytes)
  localparam int unsigned MAX_FRAME_LENGTH = 64;
  localparam int unsigned MIN_FRAME_LENGTH = 2;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned LENGTH_W = 7;
  localparam int unsigned ERROR_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] CHECKSUM_GOOD = 8'hFF;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'b1;
  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h02;
  localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h03;

  // Result kinds
  localparam logic KIND_DATA     = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  // Frame error codes, latest one wins
  localparam logic [ERROR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_OVERRUN  = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_CHECKSUM = 2'd2;
  localparam logic [ERROR_W-1:0] ERR_END      = 2'd3;

  // One result word
  typedef struct packed {
    logic                result_kind;
    logic [INDEX_W-1:0]  data_index;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   message_id;
    logic [BYTE_W-1:0]   command_code;
    logic [LENGTH_W-1:0] frame_length;
    logic [ERROR_W-1:0]  error_code;
    logic [BYTE_W-1:0]   bad_end_byte;
  } scfp_result_t;

endpackage
`default_nettype wire

### hdl/scfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_parser
// Frame phase machine: consumes one byte per step and forms the result word.
// ----------------------------------------------------------------------------
module scfp_parser (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [scfp_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [scfp_pkg::BYTE_W-1:0] start_marker,
  input  wire logic [scfp_pkg::BYTE_W-1:0] end_marker,
  output logic                             res_valid,
  output scfp_pkg::scfp_result_t           res
);
  import scfp_pkg::*;

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_LENGTH = 7'b0000010,
    PH_ID     = 7'b0000100,
    PH_CMD    = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_SUM    = 7'b0100000,
    PH_END    = 7'b1000000
  } phase_t;

  localparam logic [BYTE_W-1:0]   MAX_LEN_B = BYTE_W'(MAX_FRAME_LENGTH);
  localparam logic [BYTE_W-1:0]   MIN_LEN_B = BYTE_W'(MIN_FRAME_LENGTH);
  localparam logic [LENGTH_W-1:0] MIN_LEN   = LENGTH_W'(MIN_FRAME_LENGTH);

  phase_t              phase_r, phase_nxt;
  logic [LENGTH_W-1:0] length_r, length_nxt;
  logic [INDEX_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0]   id_r, id_nxt;
  logic [BYTE_W-1:0]   cmd_r, cmd_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [ERROR_W-1:0]  err_r, err_nxt;

  logic [BYTE_W-1:0]   sum_add;
  logic [LENGTH_W-1:0] count_inc;
  logic [LENGTH_W-1:0] data_len;
  logic                end_bad;

  assign sum_add   = sum_r + rx_byte;
  assign count_inc = {1'b0, count_r} + LENGTH_W'(1);
  assign data_len  = length_r - MIN_LEN;
  assign end_bad   = (rx_byte != end_marker);

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    id_nxt     = id_r;
    cmd_nxt    = cmd_r;
    sum_nxt    = sum_r;
    err_nxt    = err_r;
    unique case (phase_r)
      PH_START: begin
        if (rx_byte == start_marker) begin
          err_nxt   = ERR_NONE;
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (rx_byte > MAX_LEN_B) begin
          length_nxt = LENGTH_W'(MAX_FRAME_LENGTH);
          err_nxt    = ERR_OVERRUN;
        end else if (rx_byte < MIN_LEN_B) begin
          length_nxt = MIN_LEN;
        end else begin
          length_nxt = rx_byte[LENGTH_W-1:0];
        end
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_nxt   = rx_byte;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        sum_nxt   = sum_add;
        count_nxt = '0;
        phase_nxt = (length_r <= MIN_LEN) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        sum_nxt = sum_add;
        if (count_inc >= data_len) begin
          count_nxt = '0;
          phase_nxt = PH_SUM;
        end else begin
          count_nxt = count_inc[INDEX_W-1:0];
        end
      end
      PH_SUM: begin
        sum_nxt = sum_add;
        if (sum_add != CHECKSUM_GOOD) err_nxt = ERR_CHECKSUM;
        phase_nxt = PH_END;
      end
      PH_END: begin
        if (end_bad) err_nxt = ERR_END;
        phase_nxt = PH_START;
      end
      default: phase_nxt = PH_START;
    endcase
  end

  // Result word for the byte in hand
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (phase_r == PH_DATA) begin
      res_valid       = 1'b1;
      res.result_kind = KIND_DATA;
      res.data_index  = count_r;
      res.data_byte   = rx_byte;
    end else if (phase_r == PH_END) begin
      res_valid        = 1'b1;
      res.result_kind  = KIND_COMPLETE;
      res.message_id   = id_r;
      res.command_code = cmd_r;
      res.frame_length = length_r;
      res.error_code   = end_bad ? ERR_END : err_r;
      res.bad_end_byte = end_bad ? rx_byte : '0;
    end
  end

  // State registers, advanced once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      length_r <= '0;
      count_r  <= '0;
      id_r     <= '0;
      cmd_r    <= '0;
      sum_r    <= '0;
      err_r    <= ERR_NONE;
    end else if (step) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      id_r     <= id_nxt;
      cmd_r    <= cmd_nxt;
      sum_r    <= sum_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/serial_command_frame_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_frame_parser_core
// Parses start/length/id/command/data/checksum/end frames from a byte stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | in_rx_byte
//  out_    | output    | out_valid/out_ready  | kind, index, data, id, cmd, ...
//  cfg_    | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
//  One word per cycle while the output is not stalled; a byte is held in the input
//  register and its result is loaded into the output register when it is consumed.
//  The phase machine and the 8-bit checksum add set the single-cycle path.
//  Reset is synchronous; it empties both registers and returns to start hunt.
//  A stalled output only holds bytes that would produce a result.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // byte input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [scfp_pkg::BYTE_W-1:0]    in_rx_byte,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_result_kind,
  output logic [scfp_pkg::INDEX_W-1:0]        out_data_index,
  output logic [scfp_pkg::BYTE_W-1:0]         out_data_byte,
  output logic [scfp_pkg::BYTE_W-1:0]         out_message_id,
  output logic [scfp_pkg::BYTE_W-1:0]         out_command_code,
  output logic [scfp_pkg::LENGTH_W-1:0]       out_frame_length,
  output logic [scfp_pkg::ERROR_W-1:0]        out_error_code,
  output logic [scfp_pkg::BYTE_W-1:0]         out_bad_end_byte,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic [scfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scfp_pkg::BYTE_W-1:0]    cfg_wdata
);
  import scfp_pkg::*;

  logic [BYTE_W-1:0] start_marker_r;
  logic [BYTE_W-1:0] end_marker_r;
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r;
  scfp_result_t      out_r;

  logic              step;
  logic              res_valid;
  scfp_result_t      res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RESET;
      end_marker_r   <= END_MARKER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_MARKER: start_marker_r <= cfg_wdata;
        REG_END_MARKER:   end_marker_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Consume the held byte unless it makes a result with nowhere to go
  assign step     = in_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
  end

  scfp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (in_byte_r),
    .start_marker (start_marker_r),
    .end_marker   (end_marker_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) out_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_r.result_kind;
  assign out_data_index   = out_r.data_index;
  assign out_data_byte    = out_r.data_byte;
  assign out_message_id   = out_r.message_id;
  assign out_command_code = out_r.command_code;
  assign out_frame_length = out_r.frame_length;
  assign out_error_code   = out_r.error_code;
  assign out_bad_end_byte = out_r.bad_end_byte;

endmodule
`default_nettype wire
